[rtl/gtd_pkg.sv]
`timescale 1ns / 1ps
// gtd_pkg: shared constants, transaction structs and codes of the grid tag decoder
// depends on nothing; imported by every rtl module of the block
package gtd_pkg;

    localparam int GRID            = 4;   // cells per side of the tag grid
    localparam int GRID_IDX_W      = 3;   // cell index 0..GRID, GRID means outside the grid
    localparam int PATTERN_W       = 16;
    localparam int TAG_W           = 4;
    localparam int PIXEL_W         = 8;
    localparam int THRESH_W        = 8;
    localparam int PATCH_SIZE_DEF  = 22;
    localparam int DICT_SIZE_DEF   = 10;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd145;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_LOAD  = 1'b1
    } t_action;

    typedef struct packed {
        t_action               action;
        logic [PIXEL_W-1:0]    pixel;
        logic [TAG_W-1:0]      entry_index;
        logic [PATTERN_W-1:0]  entry_word;
    } t_in_item;

    typedef struct packed {
        logic                  matched;
        logic [TAG_W-1:0]      tag_id;
        logic [PATTERN_W-1:0]  pattern;
    } t_out_item;

    // accumulator status toward the top level
    typedef struct packed {
        logic                  last;     // next pixel closes the patch
        logic [PATTERN_W-1:0]  pattern;  // pattern including that pixel
    } t_accum_status;

endpackage

[rtl/gtd_cell_accum.sv]
`timescale 1ns / 1ps
// gtd_cell_accum: raster position tracking, per-cell sums and cell row thresholding
// depends on gtd_pkg
module gtd_cell_accum import gtd_pkg::*; #(
    parameter int PATCH_SIZE = PATCH_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [PIXEL_W-1:0]   i_pixel,
    input  logic [THRESH_W-1:0]  i_threshold,
    output t_accum_status        o_status
);

    localparam int CELL = PATCH_SIZE / GRID;
    localparam int PW   = $clog2(PATCH_SIZE);
    localparam int CW   = $clog2(CELL);
    localparam int SW   = $clog2(CELL * CELL * 255 + 1);
    localparam logic [SW-1:0] CELL_AREA = SW'(CELL * CELL);

    logic [PW-1:0]         r_col, r_row, n_col, n_row;
    logic [CW-1:0]         r_cc, r_rc, n_cc, n_rc;
    logic [GRID_IDX_W-1:0] r_kc, r_kr, n_kc, n_kr;
    logic [SW-1:0]         r_sum [GRID];
    logic [SW-1:0]         n_sum [GRID];
    logic [SW-1:0]         sum_add [GRID];
    logic [PATTERN_W-1:0]  r_pattern, n_pattern, pattern_set;
    logic [GRID-1:0]       row_bits;
    logic [SW-1:0]         limit;
    logic                  in_grid, row_done, col_end, last;

    always_comb begin
        in_grid  = (r_kc < GRID_IDX_W'(GRID)) && (r_kr < GRID_IDX_W'(GRID));
        row_done = in_grid && (r_kc == GRID_IDX_W'(GRID - 1))
                   && (r_cc == CW'(CELL - 1)) && (r_rc == CW'(CELL - 1));
        col_end  = (r_col == PW'(PATCH_SIZE - 1));
        last     = col_end && (r_row == PW'(PATCH_SIZE - 1));
        limit    = SW'(i_threshold) * CELL_AREA;

        for (int k = 0; k < GRID; k++) begin
            sum_add[k]  = r_sum[k] + ((in_grid && r_kc == GRID_IDX_W'(k)) ?
                                      SW'(i_pixel) : SW'(0));
            row_bits[k] = sum_add[k] > limit;
        end

        pattern_set = r_pattern;
        if (row_done) begin
            pattern_set = r_pattern | (PATTERN_W'(row_bits) << {r_kr[1:0], 2'b00});
        end

        o_status.last    = last;
        o_status.pattern = pattern_set;

        // raster advance
        n_col = r_col + PW'(1);
        n_row = r_row;
        n_rc  = r_rc;
        n_kr  = r_kr;
        if (r_cc == CW'(CELL - 1)) begin
            n_cc = '0;
            n_kc = (r_kc == GRID_IDX_W'(GRID)) ? r_kc : r_kc + GRID_IDX_W'(1);
        end else begin
            n_cc = r_cc + CW'(1);
            n_kc = r_kc;
        end
        if (col_end) begin
            n_col = '0;
            n_cc  = '0;
            n_kc  = '0;
            n_row = r_row + PW'(1);
            if (r_rc == CW'(CELL - 1)) begin
                n_rc = '0;
                n_kr = (r_kr == GRID_IDX_W'(GRID)) ? r_kr : r_kr + GRID_IDX_W'(1);
            end else begin
                n_rc = r_rc + CW'(1);
            end
        end

        n_pattern = pattern_set;
        for (int k = 0; k < GRID; k++) begin
            n_sum[k] = row_done ? SW'(0) : sum_add[k];
        end

        // patch complete: back to the origin with clean sums
        if (last) begin
            n_col     = '0;
            n_row     = '0;
            n_cc      = '0;
            n_rc      = '0;
            n_kc      = '0;
            n_kr      = '0;
            n_pattern = '0;
            for (int k = 0; k < GRID; k++) begin
                n_sum[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_cc      <= '0;
            r_rc      <= '0;
            r_kc      <= '0;
            r_kr      <= '0;
            r_pattern <= '0;
            for (int k = 0; k < GRID; k++) begin
                r_sum[k] <= '0;
            end
        end else if (i_en) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_cc      <= n_cc;
            r_rc      <= n_rc;
            r_kc      <= n_kc;
            r_kr      <= n_kr;
            r_pattern <= n_pattern;
            for (int k = 0; k < GRID; k++) begin
                r_sum[k] <= n_sum[k];
            end
        end
    end

endmodule

[rtl/gtd_dict_match.sv]
`timescale 1ns / 1ps
// gtd_dict_match: dictionary word registers, pattern hold stage, priority compare
// and the result output register; depends on gtd_pkg
module gtd_dict_match import gtd_pkg::*; #(
    parameter int DICT_SIZE = DICT_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [TAG_W-1:0]      i_wr_index,
    input  logic [PATTERN_W-1:0]  i_wr_word,
    input  logic                  i_pat_valid,
    input  logic [PATTERN_W-1:0]  i_pat,
    output logic                  o_pat_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_ready
);

    logic [PATTERN_W-1:0] r_dict [DICT_SIZE];
    logic                 r_cmp_valid;
    logic [PATTERN_W-1:0] r_cmp_pat;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;
    logic                 out_free;
    logic                 hit;
    logic [TAG_W-1:0]     hit_id;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pat_ready = !r_cmp_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // lowest matching slot wins
    always_comb begin
        hit    = 1'b0;
        hit_id = '0;
        for (int k = 0; k < DICT_SIZE; k++) begin
            if (!hit && r_dict[k] == r_cmp_pat) begin
                hit    = 1'b1;
                hit_id = TAG_W'(k);
            end
        end
        n_out.matched = hit;
        n_out.tag_id  = hit_id;
        n_out.pattern = r_cmp_pat;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DICT_SIZE; k++) begin
            if (i_wr_en && i_wr_index == TAG_W'(k)) begin
                r_dict[k] <= i_wr_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pat_ready) begin
                r_cmp_valid <= i_pat_valid;
            end
            if (out_free) begin
                r_out_valid <= r_cmp_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pat_ready && i_pat_valid) begin
            r_cmp_pat <= i_pat;
        end
        if (out_free && r_cmp_valid) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/grid_tag_decoder.sv]
`timescale 1ns / 1ps
// grid_tag_decoder: top level of the 4x4 grid tag decoder
// depends on gtd_pkg, gtd_cell_accum and gtd_dict_match
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_ready       i_in_data  (t_in_item)
//  output    out        o_out_valid / i_out_ready     o_out_data (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_data (threshold)
//
// one input transaction per clock, save for the waits below; the input
// register feeds the cell accumulator, and the result of a patch passes through the
// pattern hold stage, then the output register, before it is offered
// synchronous active-low reset clears position, sums, pattern and valid flags;
// dictionary words hold no reset value and must be loaded before the first patch
// one waiting result stalls nothing; once the hold stage holds a second one, the
// closing pixel of the following patch and any dictionary load wait, while
// ordinary pixels keep streaming
module grid_tag_decoder import gtd_pkg::*; #(
    parameter int PATCH_SIZE = PATCH_SIZE_DEF,
    parameter int DICT_SIZE  = DICT_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [THRESH_W-1:0]  i_cfg_data
);

    localparam logic [TAG_W:0] DICT_LIMIT = (TAG_W + 1)'(DICT_SIZE);

    logic                 r_in_valid;
    t_in_item             r_in;
    logic [THRESH_W-1:0]  r_threshold;
    t_accum_status        acc_status;
    logic                 in_is_pixel;
    logic                 in_move;
    logic                 pat_ready;
    logic                 slot_ok;

    // threshold register is always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // held transaction leaves unless it closes a patch or loads a word while
    // the pattern hold stage cannot take a new entry
    assign in_is_pixel = (r_in.action == ACT_PIXEL);
    assign in_move     = r_in_valid && ((in_is_pixel && !acc_status.last) || pat_ready);
    assign o_in_ready  = !r_in_valid || in_move;
    assign slot_ok     = {1'b0, r_in.entry_index} < DICT_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    gtd_cell_accum #(
        .PATCH_SIZE (PATCH_SIZE)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_move && in_is_pixel),
        .i_pixel     (r_in.pixel),
        .i_threshold (r_threshold),
        .o_status    (acc_status)
    );

    // out-of-range slots are dropped here
    gtd_dict_match #(
        .DICT_SIZE (DICT_SIZE)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (in_move && !in_is_pixel && slot_ok),
        .i_wr_index  (r_in.entry_index),
        .i_wr_word   (r_in.entry_word),
        .i_pat_valid (in_move && in_is_pixel && acc_status.last),
        .i_pat       (acc_status.pattern),
        .o_pat_ready (pat_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

[test/grid_tag_decoder_tb.sv]
`timescale 1ns / 1ps
// grid_tag_decoder_tb: self-checking testbench of the 4x4 grid tag decoder
// depends on gtd_pkg and grid_tag_decoder; streams patches and checks every decode
module grid_tag_decoder_tb;
    import gtd_pkg::*;

    localparam int PATCH       = PATCH_SIZE_DEF;
    localparam int CELL        = PATCH / GRID;
    localparam int USED        = GRID * CELL;
    localparam int DICT        = DICT_SIZE_DEF;
    localparam int LIMIT       = 400000;   // cycles, far above a slow correct run
    localparam int HOLD_CYCLES = 2000;     // long receiver hold-off, outlasts three patches
    localparam int SETTLE      = 8;        // three-stage pipe plus margin

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_CFG,
        ROW_PATCH
    } t_row_kind;

    // how the pixels of a patch are made
    typedef enum logic [1:0] {
        FILL_FLAT,     // every pixel of the used square at one level
        FILL_SHAPED,   // cell pixels drawn over the threshold for a one, up to it for a zero
        FILL_EDGE,     // cell sums right at the threshold boundary
        FILL_NOISE     // uniform random pixels
    } t_fill;

    typedef struct packed {
        t_row_kind     kind;
        logic [3:0]    slot;       // dictionary slot for a load
        logic [15:0]   word;       // load word or target pattern of a patch
        t_fill         fill;
        logic [7:0]    level;      // flat pixel level or threshold value
        logic [3:0]    load_pct;   // chance of a load between pixels, percent
        logic          pinned;     // expected decode typed in below
        t_out_item     exp;
    } t_dir_row;

    localparam t_out_item NO_RESULT = '0;

    // directed part: dictionary with a duplicate word, ignored slots, flat
    // patches at the extremes and at the threshold boundary, first-match rule
    t_dir_row directed_rows [26] = '{
        '{ROW_LOAD,  4'd0,  16'hFFFF, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd1,  16'h8001, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd2,  16'h1234, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd3,  16'hA5A5, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd4,  16'h0F0F, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd5,  16'hA5A5, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd6,  16'h0001, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd7,  16'h8000, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd8,  16'h5AC3, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd9,  16'h0000, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd10, 16'h7777, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_LOAD,  4'd15, 16'hFFFF, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd0,   4'd0, 1'b1, {1'b1, 4'd9, 16'h0000}},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd255, 4'd0, 1'b1, {1'b1, 4'd0, 16'hFFFF}},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd145, 4'd0, 1'b1, {1'b1, 4'd9, 16'h0000}},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd146, 4'd0, 1'b1, {1'b1, 4'd0, 16'hFFFF}},
        '{ROW_PATCH, 4'd0,  16'hA5A5, FILL_SHAPED, 8'd0,   4'd0, 1'b1, {1'b1, 4'd3, 16'hA5A5}},
        '{ROW_PATCH, 4'd0,  16'h8001, FILL_EDGE,   8'd0,   4'd0, 1'b1, {1'b1, 4'd1, 16'h8001}},
        '{ROW_PATCH, 4'd0,  16'h7777, FILL_SHAPED, 8'd0,   4'd0, 1'b1, {1'b0, 4'd0, 16'h7777}},
        '{ROW_PATCH, 4'd0,  16'h0F0F, FILL_SHAPED, 8'd0,   4'd0, 1'b1, {1'b1, 4'd4, 16'h0F0F}},
        '{ROW_CFG,   4'd0,  16'h0000, FILL_FLAT,   8'd0,   4'd0, 1'b0, NO_RESULT},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd0,   4'd0, 1'b1, {1'b1, 4'd9, 16'h0000}},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd1,   4'd0, 1'b1, {1'b1, 4'd0, 16'hFFFF}},
        '{ROW_CFG,   4'd0,  16'h0000, FILL_FLAT,   8'd255, 4'd0, 1'b0, NO_RESULT},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_FLAT,   8'd255, 4'd0, 1'b1, {1'b1, 4'd9, 16'h0000}},
        '{ROW_PATCH, 4'd0,  16'h0000, FILL_NOISE,  8'd0,   4'd2, 1'b0, NO_RESULT}
    };

    // dut connections, all inputs known from time zero
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_item            in_data   = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [THRESH_W-1:0] cfg_data  = '0;
    logic                in_ready;
    logic                out_valid;
    t_out_item           out_data;
    logic                cfg_ready;

    // decoder shadow: threshold, running cell sums, finished bits, dictionary
    int unsigned         thr_level = THRESHOLD_RESET;
    int unsigned         row_sums [GRID];
    logic [15:0]         seen_bits;
    int unsigned         pix_row;
    int unsigned         pix_col;
    logic [15:0]         dict_words [DICT];
    t_out_item           pending_decodes [$];

    // typed-in expectation that replaces the shadow for one directed patch
    bit                  pin_on;
    t_out_item           pin_val;

    bit                  bursts_on = 1'b1;   // random idling on both sides
    bit                  hold_req  = 1'b0;   // asks the receiver for a long hold-off
    int                  cycle_count;
    int                  errors;
    int                  n_patches;
    int                  n_matched;
    int                  n_loads;
    int                  n_cfg;
    int                  n_results;

    grid_tag_decoder #(
        .PATCH_SIZE (PATCH),
        .DICT_SIZE  (DICT)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("%0t: timeout with %0d decodes outstanding", $realtime,
                     pending_decodes.size());
            $display("simulation failed");
            $finish;
        end
    end

    // shadow of the decoder, advanced once per accepted input transaction
    function automatic void advance_decoder(t_in_item it);
        int unsigned k;
        bit          closing;
        t_out_item   res;
        if (it.action == ACT_LOAD) begin
            // slots past the dictionary are dropped
            if (it.entry_index < DICT)
                dict_words[it.entry_index] = it.entry_word;
            n_loads++;
            return;
        end
        // pixels outside the used square only move the raster position
        if (pix_row < USED && pix_col < USED) begin
            row_sums[pix_col / CELL] += it.pixel;
            if (pix_col == USED - 1 && pix_row % CELL == CELL - 1) begin
                // a cell row is complete: mean above threshold gives a one
                for (k = 0; k < GRID; k++) begin
                    if (row_sums[k] > thr_level * CELL * CELL)
                        seen_bits[(pix_row / CELL) * GRID + k] = 1'b1;
                    row_sums[k] = 0;
                end
            end
        end
        closing = (pix_col >= PATCH - 1) && (pix_row >= PATCH - 1);
        if (pix_col >= PATCH - 1) begin
            pix_col = 0;
            pix_row++;
        end else begin
            pix_col++;
        end
        if (closing) begin
            // lowest matching slot wins
            res = '0;
            for (k = 0; k < DICT; k++) begin
                if (!res.matched && dict_words[k] == seen_bits) begin
                    res.matched = 1'b1;
                    res.tag_id  = k[TAG_W-1:0];
                end
            end
            res.pattern = seen_bits;
            if (pin_on)
                res = pin_val;
            pending_decodes = {pending_decodes, res};
            if (res.matched)
                n_matched++;
            n_patches++;
            pix_row   = 0;
            pix_col   = 0;
            seen_bits = '0;
            for (k = 0; k < GRID; k++)
                row_sums[k] = 0;
        end
    endfunction

    // result checker: each decode against the oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected decode, expected none, actual %b/%0d/%h",
                         $realtime, out_data.matched, out_data.tag_id, out_data.pattern);
                errors++;
            end else begin
                want = pending_decodes.pop_front();
                n_results++;
                if (out_data.matched !== want.matched) begin
                    $display("%0t: matched mismatch, expected %b, actual %b",
                             $realtime, want.matched, out_data.matched);
                    errors++;
                end
                if (out_data.tag_id !== want.tag_id) begin
                    $display("%0t: tag_id mismatch, expected %0d, actual %0d",
                             $realtime, want.tag_id, out_data.tag_id);
                    errors++;
                end
                if (out_data.pattern !== want.pattern) begin
                    $display("%0t: pattern mismatch, expected %h, actual %h",
                             $realtime, want.pattern, out_data.pattern);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (bursts_on && $urandom_range(0, 11) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one transaction, optionally after a short gap, and wait for it
    // to be taken; valid is left high so the next item can follow at once
    task automatic drive_item(t_in_item it, bit gaps_ok);
        int gap;
        gap = 0;
        if (gaps_ok && bursts_on && $urandom_range(0, 24) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(posedge clk);
        end while (!in_ready);
        advance_decoder(it);
    endtask

    // one dictionary load, word either the hint or random
    task automatic send_load(logic [15:0] hint, bit gaps_ok);
        t_in_item it;
        it.action      = ACT_LOAD;
        it.pixel       = 8'($urandom);
        it.entry_index = 4'($urandom_range(0, 15));
        it.entry_word  = $urandom_range(0, 1) ? hint : 16'($urandom);
        drive_item(it, gaps_ok);
    endtask

    // wait until every pending decode has come out
    task automatic drain();
        while (pending_decodes.size() != 0)
            @(posedge clk);
    endtask

    // threshold write, only with the decoder idle
    task automatic write_threshold(logic [7:0] value);
        in_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_level = value;
        n_cfg++;
    endtask

    // one full patch in raster order, loads sprinkled in at load_pct percent
    task automatic send_patch(t_fill fill, logic [15:0] target, logic [7:0] level,
                              int load_pct, bit gaps_ok);
        t_in_item    it;
        int unsigned r;
        int unsigned c;
        bit          one;
        int unsigned hi_lo;
        for (r = 0; r < PATCH; r++) begin
            for (c = 0; c < PATCH; c++) begin
                if (load_pct > 0 && $urandom_range(0, 99) < load_pct)
                    send_load(target, gaps_ok);
                it.action      = ACT_PIXEL;
                it.entry_index = 4'($urandom);
                it.entry_word  = 16'($urandom);
                one   = target[(r / CELL) * GRID + c / CELL];
                hi_lo = (thr_level < 255) ? thr_level + 1 : 255;
                if (r >= USED || c >= USED || fill == FILL_NOISE) begin
                    it.pixel = 8'($urandom);
                end else begin
                    case (fill)
                        FILL_FLAT: begin
                            it.pixel = level;
                        end
                        FILL_SHAPED: begin
                            it.pixel = one ? 8'($urandom_range(hi_lo, 255))
                                           : 8'($urandom_range(0, thr_level));
                        end
                        default: begin
                            // one pixel a step over threshold tips a cell to one
                            it.pixel = thr_level[7:0];
                            if (one && r % CELL == 0 && c % CELL == 0)
                                it.pixel = hi_lo[7:0];
                        end
                    endcase
                end
                drive_item(it, gaps_ok);
            end
        end
    endtask

    // patch of random kind, mostly shaped toward a stored word
    task automatic send_random_patch(bit gaps_ok);
        int          pick;
        logic [15:0] target;
        pick   = $urandom_range(0, 9);
        target = ($urandom_range(0, 9) < 7) ? dict_words[$urandom_range(0, DICT - 1)]
                                            : 16'($urandom);
        if (pick < 6)
            send_patch(FILL_SHAPED, target, 8'd0, ($urandom_range(0, 3) == 0) ? 1 : 0,
                       gaps_ok);
        else if (pick < 8)
            send_patch(FILL_EDGE, target, 8'd0, 0, gaps_ok);
        else if (pick == 8)
            send_patch(FILL_NOISE, target, 8'd0, 2, gaps_ok);
        else
            send_patch(FILL_FLAT, target, 8'($urandom), 0, gaps_ok);
    endtask

    initial begin
        int          i;
        int          p;
        int          n;
        t_in_item    it;
        int unsigned thr_plan [7];

        for (i = 0; i < GRID; i++)
            row_sums[i] = 0;
        for (i = 0; i < DICT; i++)
            dict_words[i] = '0;
        seen_bits = '0;
        pix_row   = 0;
        pix_col   = 0;

        // reset held from time zero, then released once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < 26; i++) begin
            case (directed_rows[i].kind)
                ROW_LOAD: begin
                    it.action      = ACT_LOAD;
                    it.pixel       = 8'($urandom);
                    it.entry_index = directed_rows[i].slot;
                    it.entry_word  = directed_rows[i].word;
                    drive_item(it, 1'b1);
                end
                ROW_CFG: begin
                    write_threshold(directed_rows[i].level);
                end
                default: begin
                    pin_on  = directed_rows[i].pinned;
                    pin_val = directed_rows[i].exp;
                    send_patch(directed_rows[i].fill, directed_rows[i].word,
                               directed_rows[i].level, directed_rows[i].load_pct, 1'b1);
                    pin_on  = 1'b0;
                end
            endcase
        end

        // random phases, one threshold each, extremes included
        thr_plan = '{0, 255, $urandom_range(0, 255), 1, 254, $urandom_range(0, 255), 145};
        for (p = 0; p < 7; p++) begin
            write_threshold(thr_plan[p][7:0]);
            repeat (3) send_load(dict_words[$urandom_range(0, DICT - 1)], 1'b1);
            if (p == 3) begin
                // receiver holds off while patches stream back to back: the first
                // decode sits in the output register, the second in the hold
                // stage, so the closing pixel of the third patch has to wait
                hold_req = 1'b1;
                repeat (3) send_random_patch(1'b0);
                // sender stands still until the pipe is empty
                in_valid <= 1'b0;
                drain();
            end
            for (n = 0; n < 5; n++)
                send_random_patch($urandom_range(0, 3) != 0);
        end

        // closing stretch at full rate on both sides
        bursts_on = 1'b0;
        for (n = 0; n < 4; n++)
            send_random_patch(1'b1);
        in_valid <= 1'b0;

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d patches (%0d matching a stored word), %0d dictionary loads",
                 n_patches, n_matched, n_loads);
        $display("over %0d threshold writes incl. 0 and 255; %0d decodes checked, %0d errors",
                 n_cfg, n_results, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/gtd_pkg.sv
rtl/gtd_cell_accum.sv
rtl/gtd_dict_match.sv
rtl/grid_tag_decoder.sv
test/grid_tag_decoder_tb.sv
